// File: sv/mdau_pkg.sv
`timescale 1ns / 1ps
package mdau_pkg;

	// Field widths of one bus access and of its answer
	localparam int unsigned KIND_W = 1;
	localparam int unsigned SEL_W  = 4;
	localparam int unsigned DATA_W = 8;

	// Operand, product and sum widths
	localparam int unsigned OPND_W = 16;
	localparam int unsigned PROD_W = 32;
	localparam int unsigned SUM_W  = 40;

	// Access kinds
	localparam logic [KIND_W-1:0] KIND_READ  = 1'b0;
	localparam logic [KIND_W-1:0] KIND_WRITE = 1'b1;

	// Register map
	localparam logic [SEL_W-1:0] SEL_CTRL = 4'd0;
	localparam logic [SEL_W-1:0] SEL_A_LO = 4'd1;
	localparam logic [SEL_W-1:0] SEL_A_HI = 4'd2;
	localparam logic [SEL_W-1:0] SEL_B_LO = 4'd3;
	localparam logic [SEL_W-1:0] SEL_B_HI = 4'd4;
	localparam logic [SEL_W-1:0] SEL_RES0 = 4'd5;
	localparam logic [SEL_W-1:0] SEL_RES4 = 4'd9;
	localparam logic [SEL_W-1:0] SEL_OVF  = 4'd10;

	// Read answers
	localparam logic [DATA_W-1:0] RD_NONE  = 8'hFF;
	localparam logic [DATA_W-1:0] RD_WRITE = 8'h00;

	// Control register bits
	localparam int unsigned CTRL_DIV_BIT = 0;
	localparam int unsigned CTRL_ACC_BIT = 1;

	// Serial step counts (count runs down to zero)
	localparam logic [3:0] MUL_STEPS_M1 = 4'd14;
	localparam logic [3:0] DIV_STEPS_M1 = 4'd15;

	// Arithmetic sequencer states
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MUL  = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_FIX  = 4'b1000
	} mdau_state_t;

endpackage

// File: sv/mdau_req_if.sv
`timescale 1ns / 1ps
interface mdau_req_if;
	logic                             valid;
	logic                             ready;
	logic [mdau_pkg::KIND_W-1:0]      kind;
	logic [mdau_pkg::SEL_W-1:0]       reg_select;
	logic [mdau_pkg::DATA_W-1:0]      write_data;

	modport source (output valid, kind, reg_select, write_data, input ready);
	modport sink (input valid, kind, reg_select, write_data, output ready);
endinterface

// File: sv/mdau_rsp_if.sv
`timescale 1ns / 1ps
interface mdau_rsp_if;
	logic                             valid;
	logic                             ready;
	logic [mdau_pkg::DATA_W-1:0]      read_data;

	modport source (output valid, read_data, input ready);
	modport sink (input valid, read_data, output ready);
endinterface

// File: sv/multiply_divide_accumulate_unit_core.sv
`timescale 1ns / 1ps
// Register-mapped multiply / divide / accumulate unit.
// req carries one bus access per item: kind (read or write), reg_select and
// write_data. rsp returns one item per access: the byte read, or 0 for writes.
// Reads of the result bytes and the overflow flag answer from the current
// state; other registers read 0xFF.
// Every accepted access places its answer in a two-entry output queue at
// acceptance, so rsp.valid is high in the cycle after acceptance.
// Writing operand B high starts the selected operation on a shared radix-2
// sequencer: multiply and accumulate take 15 shift-add steps plus one final
// step, divide takes 16 restoring steps plus one sign-fix step. req.ready
// stays low while the sequencer runs; a zero divisor finishes at once.
// When the receiver stalls, up to two answers wait in the queue; req.ready
// drops when the queue is full and no answer leaves in that cycle.
// Reset clears operands, result sum, overflow flag, modes, the sequencer state
// and step count, and empties the output queue.
module multiply_divide_accumulate_unit_core (
	input  logic       clk,
	input  logic       arst_n,
	mdau_req_if.sink   req,
	mdau_rsp_if.source rsp
);

	// Architectural state
	logic [mdau_pkg::OPND_W-1:0] operand_a_q;
	logic [mdau_pkg::OPND_W-1:0] operand_b_q;
	logic [mdau_pkg::SUM_W-1:0]  result_sum_q;
	logic                        ovf_q;
	logic                        div_mode_q;
	logic                        acc_mode_q;

	// Sequencer
	mdau_pkg::mdau_state_t       state_q;
	logic [3:0]                  step_q;
	logic [mdau_pkg::OPND_W-1:0] opnd_q;
	logic [mdau_pkg::OPND_W-1:0] sh_q;
	logic [mdau_pkg::OPND_W-1:0] rem_q;
	logic [mdau_pkg::PROD_W-1:0] prod_q;
	logic                        neg_q;

	// Output queue
	logic [1:0]                  out_cnt_q;
	logic [mdau_pkg::DATA_W-1:0] head_q;
	logic [mdau_pkg::DATA_W-1:0] tail_q;

	logic                        acc_in;
	logic                        wr;
	logic                        start;
	logic                        div_op;
	logic                        pop;
	logic [mdau_pkg::OPND_W-1:0] new_b;
	logic [mdau_pkg::OPND_W-1:0] abs_a;
	logic [mdau_pkg::PROD_W-1:0] a_ext;
	logic [mdau_pkg::PROD_W-1:0] prod_init;
	logic [mdau_pkg::PROD_W-1:0] opnd_ext;
	logic [mdau_pkg::PROD_W-1:0] mul_next;
	logic [mdau_pkg::OPND_W:0]   trial;
	logic [mdau_pkg::OPND_W+1:0] diff;
	logic                        q_bit;
	logic                        r_zero;
	logic [mdau_pkg::OPND_W-1:0] q_fix;
	logic [mdau_pkg::OPND_W-1:0] r_fix;
	logic [mdau_pkg::SUM_W+1:0]  acc_sum;
	logic [2:0]                  byte_idx;
	logic [mdau_pkg::DATA_W-1:0] rd_data;

	// Handshake
	assign acc_in    = req.valid && req.ready;
	assign pop       = rsp.valid && rsp.ready;
	assign req.ready = (state_q == mdau_pkg::ST_IDLE) && ((out_cnt_q != 2'd2) || rsp.ready);
	assign rsp.valid = (out_cnt_q != 2'd0);
	assign rsp.read_data = head_q;

	assign wr     = acc_in && (req.kind == mdau_pkg::KIND_WRITE);
	assign start  = wr && (req.reg_select == mdau_pkg::SEL_B_HI);
	assign div_op = div_mode_q && !acc_mode_q;
	assign new_b  = {req.write_data, operand_b_q[7:0]};

	// Operand preparation
	assign abs_a     = operand_a_q[15] ? 16'(~operand_a_q + 16'd1) : operand_a_q;
	assign a_ext     = {{16{operand_a_q[15]}}, operand_a_q};
	assign prod_init = new_b[15] ? 32'(~a_ext + 32'd1) : '0;

	// One shift-add step: P = 2P + a * b_i
	assign opnd_ext = {{16{opnd_q[15]}}, opnd_q};
	assign mul_next = {prod_q[30:0], 1'b0} + (sh_q[15] ? opnd_ext : '0);

	// One restoring divide step
	assign trial = {rem_q, sh_q[15]};
	assign diff  = {1'b0, trial} - {2'b00, opnd_q};
	assign q_bit = !diff[17];

	// Floor correction for a negative dividend
	assign r_zero = (rem_q == '0);
	always_comb begin
		if (!neg_q) begin
			q_fix = sh_q;
			r_fix = rem_q;
		end else if (r_zero) begin
			q_fix = 16'(~sh_q + 16'd1);
			r_fix = rem_q;
		end else begin
			q_fix = ~sh_q;
			r_fix = 16'(opnd_q - rem_q);
		end
	end

	// Exact sum of the unsigned total and the signed product
	assign acc_sum = {2'b00, result_sum_q} + {{10{prod_q[31]}}, prod_q};

	// Read answer
	assign byte_idx = 3'(req.reg_select - mdau_pkg::SEL_RES0);
	always_comb begin
		if (req.kind == mdau_pkg::KIND_WRITE) begin
			rd_data = mdau_pkg::RD_WRITE;
		end else if (req.reg_select inside {[mdau_pkg::SEL_RES0:mdau_pkg::SEL_RES4]}) begin
			rd_data = result_sum_q[{byte_idx, 3'b000} +: 8];
		end else if (req.reg_select == mdau_pkg::SEL_OVF) begin
			rd_data = {ovf_q, 7'b0};
		end else begin
			rd_data = mdau_pkg::RD_NONE;
		end
	end

	// Register writes and the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			operand_a_q  <= '0;
			operand_b_q  <= '0;
			result_sum_q <= '0;
			ovf_q        <= 1'b0;
			div_mode_q   <= 1'b0;
			acc_mode_q   <= 1'b0;
			state_q      <= mdau_pkg::ST_IDLE;
			step_q       <= '0;
		end else begin
			if (wr) begin
				case (req.reg_select)
					mdau_pkg::SEL_CTRL: begin
						div_mode_q <= req.write_data[mdau_pkg::CTRL_DIV_BIT];
						acc_mode_q <= req.write_data[mdau_pkg::CTRL_ACC_BIT];
						if (req.write_data[mdau_pkg::CTRL_ACC_BIT]) begin
							result_sum_q <= '0;
						end
					end
					mdau_pkg::SEL_A_LO: operand_a_q[7:0]  <= req.write_data;
					mdau_pkg::SEL_A_HI: operand_a_q[15:8] <= req.write_data;
					mdau_pkg::SEL_B_LO: operand_b_q[7:0]  <= req.write_data;
					mdau_pkg::SEL_B_HI: begin
						operand_b_q <= '0;
						if (div_op) begin
							operand_a_q <= '0;
							if (new_b == '0) begin
								result_sum_q <= '0;
							end else begin
								state_q <= mdau_pkg::ST_DIV;
								step_q  <= mdau_pkg::DIV_STEPS_M1;
							end
						end else begin
							state_q <= mdau_pkg::ST_MUL;
							step_q  <= mdau_pkg::MUL_STEPS_M1;
						end
					end
					default: ;
				endcase
			end

			// Advance the sequencer
			case (state_q)
				mdau_pkg::ST_MUL, mdau_pkg::ST_DIV: begin
					step_q <= 4'(step_q - 4'd1);
					if (step_q == '0) begin
						state_q <= mdau_pkg::ST_FIX;
					end
				end
				mdau_pkg::ST_FIX: begin
					state_q <= mdau_pkg::ST_IDLE;
					if (acc_mode_q) begin
						result_sum_q <= acc_sum[mdau_pkg::SUM_W-1:0];
						ovf_q        <= (acc_sum[41:40] != 2'b00);
					end else if (!div_mode_q) begin
						result_sum_q <= {8'b0, prod_q};
					end else begin
						result_sum_q <= {8'b0, r_fix, q_fix};
					end
				end
				default: ;
			endcase
		end
	end

	// Shift registers of the serial datapath
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q  <= operand_a_q[15];
			rem_q  <= '0;
			prod_q <= prod_init;
			if (div_op) begin
				opnd_q <= new_b;
				sh_q   <= abs_a;
			end else begin
				opnd_q <= operand_a_q;
				sh_q   <= {new_b[14:0], 1'b0};
			end
		end else if (state_q == mdau_pkg::ST_MUL) begin
			prod_q <= mul_next;
			sh_q   <= {sh_q[14:0], 1'b0};
		end else if (state_q == mdau_pkg::ST_DIV) begin
			rem_q <= q_bit ? diff[15:0] : trial[15:0];
			sh_q  <= {sh_q[14:0], q_bit};
		end
	end

	// Output queue control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_cnt_q <= '0;
		end else if (acc_in && !pop) begin
			out_cnt_q <= 2'(out_cnt_q + 2'd1);
		end else if (pop && !acc_in) begin
			out_cnt_q <= 2'(out_cnt_q - 2'd1);
		end
	end

	// Output queue data
	always_ff @(posedge clk) begin
		if (acc_in && pop) begin
			if (out_cnt_q == 2'd2) begin
				head_q <= tail_q;
				tail_q <= rd_data;
			end else begin
				head_q <= rd_data;
			end
		end else if (acc_in) begin
			if (out_cnt_q == 2'd0) begin
				head_q <= rd_data;
			end else begin
				tail_q <= rd_data;
			end
		end else if (pop) begin
			head_q <= tail_q;
		end
	end

`ifndef NO_ASSERTIONS
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_cnt_q != 2'd3)
		else $error("output queue count out of range");

	a_start_clears_b: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> operand_b_q == '0)
		else $error("operand B not cleared after start");

	a_fix_ends: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == mdau_pkg::ST_FIX |=> state_q == mdau_pkg::ST_IDLE)
		else $error("sequencer did not finish after final step");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mdau_pkg::ST_MUL || state_q == mdau_pkg::ST_DIV) |-> !acc_in)
		else $error("item accepted while sequencer busy");

	a_rsp_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		acc_in |=> rsp.valid)
		else $error("answer missing after accepted item");
`endif

endmodule

// File: tb/sv/multiply_divide_accumulate_unit_core_tb.sv
`timescale 1ns / 1ps
module multiply_divide_accumulate_unit_core_tb;

	localparam int unsigned TIMEOUT_NS = 2_000_000;
	localparam int unsigned RAND_ITEMS = 2000;
	localparam int unsigned HOLD_CYC   = 60;
	localparam int unsigned TAIL_CYC   = 40;
	localparam int unsigned DIR_N      = 30;

	// Register indexes and byte values the package does not name
	localparam logic [mdau_pkg::SEL_W-1:0]  SEL_RES1  = mdau_pkg::SEL_RES0 + 4'd1;
	localparam logic [mdau_pkg::SEL_W-1:0]  SEL_RES2  = mdau_pkg::SEL_RES0 + 4'd2;
	localparam logic [mdau_pkg::SEL_W-1:0]  SEL_RES3  = mdau_pkg::SEL_RES0 + 4'd3;
	localparam logic [mdau_pkg::SEL_W-1:0]  SEL_SPARE = 4'd15;
	localparam logic [mdau_pkg::DATA_W-1:0] CTRL_DIV  = 8'(1 << mdau_pkg::CTRL_DIV_BIT);
	localparam logic [mdau_pkg::DATA_W-1:0] CTRL_ACC  = 8'(1 << mdau_pkg::CTRL_ACC_BIT);
	localparam logic [mdau_pkg::DATA_W-1:0] OVF_SET   = 8'h80;
	localparam logic [mdau_pkg::DATA_W-1:0] OVF_CLR   = 8'h00;

	typedef struct {
		logic [mdau_pkg::KIND_W-1:0] kind;
		logic [mdau_pkg::SEL_W-1:0]  sel;
		logic [mdau_pkg::DATA_W-1:0] data;
		bit                          chk;
		logic [mdau_pkg::DATA_W-1:0] want;
	} access_t;

	logic clk;
	logic arst_n;

	mdau_req_if req_ch ();
	mdau_rsp_if rsp_ch ();

	multiply_divide_accumulate_unit_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Mirror of the unit's registers
	logic [mdau_pkg::OPND_W-1:0] mirror_a   = '0;
	logic [mdau_pkg::OPND_W-1:0] mirror_b   = '0;
	logic [mdau_pkg::SUM_W-1:0]  mirror_sum = '0;
	logic                        mirror_ovf = 1'b0;
	logic                        mirror_div = 1'b0;
	logic                        mirror_acc = 1'b0;

	logic [mdau_pkg::DATA_W-1:0] pending_rd_q[$];
	logic                        cur_chk;
	logic [mdau_pkg::DATA_W-1:0] cur_want;

	int  err_cnt   = 0;
	int  sent_cnt  = 0;
	int  n_reads   = 0;
	int  n_mul     = 0;
	int  n_div     = 0;
	int  n_div0    = 0;
	int  n_acc     = 0;
	int  n_ovf     = 0;
	int  max_gap   = 5;
	int  max_stall = 5;
	bit  hold_long = 1'b0;
	int  n_holds   = 0;

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Apply one access to the mirror and return the byte it reads back
	function automatic logic [mdau_pkg::DATA_W-1:0] next_read_data(
			input logic [mdau_pkg::KIND_W-1:0] k,
			input logic [mdau_pkg::SEL_W-1:0] s, input logic [mdau_pkg::DATA_W-1:0] d);
		int a, b, dv, rem, quo;
		longint prod;
		logic [63:0] wide;
		logic [mdau_pkg::DATA_W-1:0] rd;
		rd = mdau_pkg::RD_WRITE;
		if (k == mdau_pkg::KIND_WRITE) begin
			case (s)
				mdau_pkg::SEL_CTRL: begin
					mirror_div = d[mdau_pkg::CTRL_DIV_BIT];
					mirror_acc = d[mdau_pkg::CTRL_ACC_BIT];
					if (mirror_acc)
						mirror_sum = '0;
				end
				mdau_pkg::SEL_A_LO: mirror_a[7:0] = d;
				mdau_pkg::SEL_A_HI: mirror_a[15:8] = d;
				mdau_pkg::SEL_B_LO: mirror_b[7:0] = d;
				mdau_pkg::SEL_B_HI: begin
					mirror_b[15:8] = d;
					a = int'($signed(mirror_a));
					b = int'($signed(mirror_b));
					prod = longint'(a) * longint'(b);
					if (mirror_acc) begin
						// add as unsigned 40-bit; anything above bit 39 flags overflow
						wide = {24'd0, mirror_sum} + 64'(prod);
						mirror_ovf = |wide[63:mdau_pkg::SUM_W];
						mirror_sum = wide[mdau_pkg::SUM_W-1:0];
						mirror_b = '0;
						n_acc++;
						if (mirror_ovf)
							n_ovf++;
					end else if (!mirror_div) begin
						mirror_sum = {{(mdau_pkg::SUM_W-mdau_pkg::PROD_W){1'b0}},
							mdau_pkg::PROD_W'(prod)};
						mirror_b = '0;
						n_mul++;
					end else begin
						// floor division: remainder always in 0..B-1
						if (mirror_b == '0) begin
							mirror_sum = '0;
							n_div0++;
						end else begin
							dv = int'(mirror_b);
							rem = a % dv;
							if (rem < 0)
								rem += dv;
							quo = (a - rem) / dv;
							mirror_sum = {8'd0, rem[15:0], quo[15:0]};
						end
						mirror_a = '0;
						mirror_b = '0;
						n_div++;
					end
				end
				default: ;
			endcase
		end else begin
			n_reads++;
			if (s >= mdau_pkg::SEL_RES0 && s <= mdau_pkg::SEL_RES4)
				rd = 8'(mirror_sum >> (8 * (s - mdau_pkg::SEL_RES0)));
			else if (s == mdau_pkg::SEL_OVF)
				rd = mirror_ovf ? OVF_SET : OVF_CLR;
			else
				rd = mdau_pkg::RD_NONE;
		end
		return rd;
	endfunction

	function automatic access_t mk(input logic [mdau_pkg::KIND_W-1:0] k,
			input logic [mdau_pkg::SEL_W-1:0] s, input logic [mdau_pkg::DATA_W-1:0] d);
		access_t r;
		r = '{k, s, d, 1'b0, mdau_pkg::RD_WRITE};
		return r;
	endfunction

	// Operand byte biased toward the extremes
	function automatic logic [mdau_pkg::DATA_W-1:0] opnd_byte();
		case ($urandom_range(7, 0))
			0: return 8'h00;
			1: return 8'hFF;
			2: return 8'h80;
			3: return 8'h7F;
			default: return 8'($urandom_range(255, 0));
		endcase
	endfunction

	// Offer one item after a random gap and hold it until accepted
	task automatic send_access(input access_t r);
		int gap;
		gap = $urandom_range(max_gap, 0);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.kind       <= r.kind;
		req_ch.reg_select <= r.sel;
		req_ch.write_data <= r.data;
		cur_chk           <= r.chk;
		cur_want          <= r.want;
		do @(posedge clk); while (!req_ch.ready);
		sent_cnt++;
	endtask

	// Check answers, then predict for the access accepted at this edge
	always @(posedge clk) begin
		logic [mdau_pkg::DATA_W-1:0] exp_rd, pred;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (pending_rd_q.size() == 0) begin
					$display("%0t: unexpected item %02h with nothing pending",
						$time, rsp_ch.read_data);
					err_cnt++;
				end else begin
					exp_rd = pending_rd_q.pop_front();
					if (rsp_ch.read_data !== exp_rd) begin
						$display("%0t: read_data mismatch: expected %02h, got %02h",
							$time, exp_rd, rsp_ch.read_data);
						err_cnt++;
					end
				end
			end
			if (req_ch.valid && req_ch.ready) begin
				pred = next_read_data(req_ch.kind, req_ch.reg_select, req_ch.write_data);
				pending_rd_q.push_back(cur_chk ? cur_want : pred);
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off on request
	initial begin
		int stall;
		rsp_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_long) begin
				stall = HOLD_CYC;
				hold_long = 1'b0;
				n_holds++;
			end else begin
				stall = $urandom_range(max_stall, 0);
			end
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
		end
	end

	initial begin
		#(TIMEOUT_NS);
		$display("multiply_divide_accumulate_unit_core_tb NOT OK");
		$finish;
	end

	initial begin
		access_t dir_tab [DIR_N];
		access_t seq_q[$];
		bit held, paused, zero_b;
		int n;
		held = 1'b0;
		paused = 1'b0;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.kind = mdau_pkg::KIND_READ;
		req_ch.reg_select = mdau_pkg::SEL_CTRL;
		req_ch.write_data = '0;
		cur_chk = 1'b0;
		cur_want = '0;

		// Reset values, unreadable and unwritable registers, multiply of the
		// most negative operands, min times max, floor divide of a negative
		// dividend, zero divisor, accumulate wrapping below zero, and a mode
		// write that clears the sum but keeps the overflow flag
		dir_tab = '{
			'{mdau_pkg::KIND_READ,  mdau_pkg::SEL_RES0, 8'h00,    1'b1, OVF_CLR},
			'{mdau_pkg::KIND_READ,  mdau_pkg::SEL_OVF,  8'h00,    1'b1, OVF_CLR},
			'{mdau_pkg::KIND_READ,  mdau_pkg::SEL_CTRL, 8'h00,    1'b1, mdau_pkg::RD_NONE},
			'{mdau_pkg::KIND_WRITE, SEL_SPARE,          8'hAA,    1'b1, mdau_pkg::RD_WRITE},
			'{mdau_pkg::KIND_READ,  SEL_SPARE,          8'h55,    1'b1, mdau_pkg::RD_NONE},
			'{mdau_pkg::KIND_WRITE, mdau_pkg::SEL_A_LO, 8'h00,    1'b1, mdau_pkg::RD_WRITE},
			'{mdau_pkg::KIND_WRITE, mdau_pkg::SEL_A_HI, 8'h80,    1'b1, mdau_pkg::RD_WRITE},
			'{mdau_pkg::KIND_WRITE, mdau_pkg::SEL_B_LO, 8'h00,    1'b1, mdau_pkg::RD_WRITE},
			'{mdau_pkg::KIND_WRITE, mdau_pkg::SEL_B_HI, 8'h80,    1'b1, mdau_pkg::RD_WRITE},
			'{mdau_pkg::KIND_READ,  SEL_RES3,           8'h00,    1'b1, 8'h40},
			'{mdau_pkg::KIND_WRITE, mdau_pkg::SEL_A_HI, 8'h7F,    1'b1, mdau_pkg::RD_WRITE},
			'{mdau_pkg::KIND_WRITE, mdau_pkg::SEL_A_LO, 8'hFF,    1'b1, mdau_pkg::RD_WRITE},
			'{mdau_pkg::KIND_WRITE, mdau_pkg::SEL_B_HI, 8'h80,    1'b1, mdau_pkg::RD_WRITE},
			'{mdau_pkg::KIND_READ,  SEL_RES3,           8'h00,    1'b0, 8'h00},
			'{mdau_pkg::KIND_WRITE, mdau_pkg::SEL_CTRL, CTRL_DIV, 1'b1, mdau_pkg::RD_WRITE},
			'{mdau_pkg::KIND_WRITE, mdau_pkg::SEL_A_LO, 8'hF9,    1'b1, mdau_pkg::RD_WRITE},
			'{mdau_pkg::KIND_WRITE, mdau_pkg::SEL_A_HI, 8'hFF,    1'b1, mdau_pkg::RD_WRITE},
			'{mdau_pkg::KIND_WRITE, mdau_pkg::SEL_B_LO, 8'h02,    1'b1, mdau_pkg::RD_WRITE},
			'{mdau_pkg::KIND_WRITE, mdau_pkg::SEL_B_HI, 8'h00,    1'b1, mdau_pkg::RD_WRITE},
			'{mdau_pkg::KIND_READ,  mdau_pkg::SEL_RES0, 8'h00,    1'b0, 8'h00},
			'{mdau_pkg::KIND_READ,  SEL_RES2,           8'h00,    1'b0, 8'h00},
			'{mdau_pkg::KIND_WRITE, mdau_pkg::SEL_B_HI, 8'h00,    1'b1, mdau_pkg::RD_WRITE},
			'{mdau_pkg::KIND_READ,  SEL_RES1,           8'h00,    1'b1, 8'h00},
			'{mdau_pkg::KIND_WRITE, mdau_pkg::SEL_CTRL, CTRL_ACC, 1'b1, mdau_pkg::RD_WRITE},
			'{mdau_pkg::KIND_WRITE, mdau_pkg::SEL_A_LO, 8'h01,    1'b1, mdau_pkg::RD_WRITE},
			'{mdau_pkg::KIND_WRITE, mdau_pkg::SEL_B_LO, 8'hFF,    1'b1, mdau_pkg::RD_WRITE},
			'{mdau_pkg::KIND_WRITE, mdau_pkg::SEL_B_HI, 8'hFF,    1'b1, mdau_pkg::RD_WRITE},
			'{mdau_pkg::KIND_READ,  mdau_pkg::SEL_OVF,  8'h00,    1'b1, OVF_SET},
			'{mdau_pkg::KIND_WRITE, mdau_pkg::SEL_CTRL, 8'hFF,    1'b1, mdau_pkg::RD_WRITE},
			'{mdau_pkg::KIND_READ,  mdau_pkg::SEL_OVF,  8'h00,    1'b1, OVF_SET}
		};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i])
			send_access(dir_tab[i]);

		while (sent_cnt < DIR_N + RAND_ITEMS) begin
			// rotate idling pattern: both sides, receiver only, sender only, none
			case ((sent_cnt / 250) % 4)
				0: begin max_gap = 5; max_stall = 5; end
				1: begin max_gap = 0; max_stall = 5; end
				2: begin max_gap = 5; max_stall = 0; end
				default: begin max_gap = 0; max_stall = 0; end
			endcase

			// fill the unit while the receiver holds off
			if (!held && sent_cnt >= 600) begin
				held = 1'b1;
				max_gap = 0;
				hold_long = 1'b1;
			end

			// drain everything before going on
			if (!paused && sent_cnt >= 1200) begin
				paused = 1'b1;
				req_ch.valid <= 1'b0;
				@(posedge clk);
				while (pending_rd_q.size() != 0) @(posedge clk);
			end

			seq_q.delete();
			if ($urandom_range(99, 0) < 15) begin
				// noise: any access to any register
				n = $urandom_range(4, 1);
				repeat (n)
					seq_q.push_back(mk(mdau_pkg::KIND_W'($urandom_range(1, 0)),
						mdau_pkg::SEL_W'($urandom_range(15, 0)),
						mdau_pkg::DATA_W'($urandom_range(255, 0))));
			end else begin
				// operation: optional mode write, operands, start, read-back
				if ($urandom_range(3, 0) == 0)
					seq_q.push_back(mk(mdau_pkg::KIND_WRITE, mdau_pkg::SEL_CTRL,
						mdau_pkg::DATA_W'($urandom_range(255, 0))));
				if ($urandom_range(3, 0) != 0)
					seq_q.push_back(mk(mdau_pkg::KIND_WRITE, mdau_pkg::SEL_A_LO,
						opnd_byte()));
				if ($urandom_range(3, 0) != 0)
					seq_q.push_back(mk(mdau_pkg::KIND_WRITE, mdau_pkg::SEL_A_HI,
						opnd_byte()));
				zero_b = ($urandom_range(9, 0) == 0);
				if ($urandom_range(7, 0) != 0)
					seq_q.push_back(mk(mdau_pkg::KIND_WRITE, mdau_pkg::SEL_B_LO,
						zero_b ? 8'h00 : opnd_byte()));
				seq_q.push_back(mk(mdau_pkg::KIND_WRITE, mdau_pkg::SEL_B_HI,
					zero_b ? 8'h00 : opnd_byte()));
				n = $urandom_range(6, 1);
				repeat (n)
					seq_q.push_back(mk(mdau_pkg::KIND_READ,
						mdau_pkg::SEL_W'($urandom_range(mdau_pkg::SEL_OVF,
							mdau_pkg::SEL_RES0)),
						mdau_pkg::DATA_W'($urandom_range(255, 0))));
			end
			foreach (seq_q[i])
				send_access(seq_q[i]);
		end

		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_rd_q.size() != 0) @(posedge clk);
		repeat (TAIL_CYC) @(posedge clk);

		$display("Ran %0d accesses, %0d of them reads: %0d multiplies, %0d divides (%0d by zero),",
			sent_cnt, n_reads, n_mul, n_div, n_div0);
		$display("%0d accumulates (%0d overflowing), %0d long receiver hold-offs, one full drain.",
			n_acc, n_ovf, n_holds);
		if (err_cnt == 0) begin
			$display("multiply_divide_accumulate_unit_core_tb OK");
		end else begin
			$display("multiply_divide_accumulate_unit_core_tb NOT OK");
		end
		$finish;
	end

endmodule
